[sv/npc_pkg.sv]
// ----------------------------------------------------------------------------
// npc_pkg
// Shared widths, codes, state type and control structs of the palette
// quantizer.
// ----------------------------------------------------------------------------
`default_nettype none

package npc_pkg;

    localparam int CHAN_W            = 8;
    localparam int IDX_W             = 6;
    localparam int DIST_W            = 18;
    localparam int CNT_W             = 7;
    localparam int SQ_W              = 2 * CHAN_W;
    localparam int COLOR_W           = 3 * CHAN_W;
    localparam int DEF_PALETTE_DEPTH = 64;

    // Function codes carried in the input word.
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_PIXEL = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic pal_wr;
        logic load_pixel;
        logic rd_en;
        logic rd_first;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

[sv/npc_in_if.sv]
// ----------------------------------------------------------------------------
// npc_in_if
// Input channel: palette writes and pixels, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface npc_in_if;
    import npc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 func;
    logic [IDX_W-1:0]     entry_index;
    logic [CHAN_W-1:0]    red_in;
    logic [CHAN_W-1:0]    green_in;
    logic [CHAN_W-1:0]    blue_in;

    modport source (
        output valid, func, entry_index, red_in, green_in, blue_in,
        input  ready
    );

    modport sink (
        input  valid, func, entry_index, red_in, green_in, blue_in,
        output ready
    );
endinterface

`default_nettype wire

[sv/npc_out_if.sv]
// ----------------------------------------------------------------------------
// npc_out_if
// Result channel: nearest palette entry and its distance, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface npc_out_if;
    import npc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [IDX_W-1:0]     best_index;
    logic [CHAN_W-1:0]    red_out;
    logic [CHAN_W-1:0]    green_out;
    logic [CHAN_W-1:0]    blue_out;
    logic [DIST_W-1:0]    best_distance;

    modport source (
        output valid, best_index, red_out, green_out, blue_out, best_distance,
        input  ready
    );

    modport sink (
        input  valid, best_index, red_out, green_out, blue_out, best_distance,
        output ready
    );
endinterface

`default_nettype wire

[sv/npc_ctrl.sv]
// ----------------------------------------------------------------------------
// npc_ctrl
// Controller: holds the color count, sequences the palette scan and hands
// the finished result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module npc_ctrl #(
    parameter int PALETTE_DEPTH = npc_pkg::DEF_PALETTE_DEPTH,
    localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [npc_pkg::CNT_W-1:0] i_cfg_wdata,
    input  wire logic                     i_valid,
    input  wire logic                     i_func,
    output logic                          o_ready,
    input  wire npc_pkg::t_sts            i_sts,
    output npc_pkg::t_cmd                 o_cmd,
    output logic [AW-1:0]                 o_rd_addr
);
    import npc_pkg::*;

    localparam int DW = $clog2(PALETTE_DEPTH + 1);
    localparam int LW = (CNT_W > DW) ? CNT_W : DW;

    t_state            r_state, n_state;
    logic [AW-1:0]     r_addr, n_addr;
    logic [AW-1:0]     r_last, n_last;
    logic [CNT_W-1:0]  r_color_count;

    logic              w_accept;
    logic [LW-1:0]     w_cnt_ext;
    logic [LW-1:0]     w_eff;
    logic [LW-1:0]     w_last_full;

    assign w_accept = i_valid && (r_state == ST_IDLE);

    // A count of zero searches entry zero only; a count past the depth
    // saturates at the depth.
    always_comb begin
        w_cnt_ext = LW'(r_color_count);
        if (w_cnt_ext == '0) begin
            w_eff = LW'(1);
        end else if (w_cnt_ext > LW'(PALETTE_DEPTH)) begin
            w_eff = LW'(PALETTE_DEPTH);
        end else begin
            w_eff = w_cnt_ext;
        end
        w_last_full = w_eff - LW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_count <= CNT_W'(1);
        end else if (i_cfg_we) begin
            r_color_count <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_addr  <= '0;
            r_last  <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_last  <= n_last;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        n_last  = r_last;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && i_func == FUNC_PIXEL) begin
                    n_state = ST_SCAN;
                    n_addr  = '0;
                    n_last  = w_last_full[AW-1:0];
                end
            end
            ST_SCAN: begin
                if (r_addr == r_last) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            ST_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        o_ready   = 1'b0;
        o_cmd     = '0;
        o_rd_addr = r_addr;
        case (r_state)
            ST_IDLE: begin
                o_ready          = 1'b1;
                o_cmd.pal_wr     = w_accept && i_func == FUNC_WRITE;
                o_cmd.load_pixel = w_accept && i_func == FUNC_PIXEL;
            end
            ST_SCAN: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_first = (r_addr == '0);
            end
            ST_DRAIN: begin
            end
            ST_DONE: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: begin
            end
        endcase
    end

    a_addr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SCAN |-> r_addr <= r_last)
        else $error("scan address ran past the last palette entry");

    a_scan_ends_at_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN && $past(r_state) == ST_SCAN)
            |-> $past(r_addr) == $past(r_last))
        else $error("scan left before reaching the last entry");

    a_done_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DONE |-> !i_sts.pipe_busy)
        else $error("result handed over while distance pipeline still busy");

endmodule

`default_nettype wire

[sv/npc_datapath.sv]
// ----------------------------------------------------------------------------
// npc_datapath
// Palette memory, distance pipeline, running minimum and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module npc_datapath #(
    parameter int PALETTE_DEPTH = npc_pkg::DEF_PALETTE_DEPTH,
    localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire npc_pkg::t_cmd             i_cmd,
    input  wire logic [AW-1:0]             i_rd_addr,
    input  wire logic [npc_pkg::IDX_W-1:0] i_entry_index,
    input  wire logic [npc_pkg::CHAN_W-1:0] i_red,
    input  wire logic [npc_pkg::CHAN_W-1:0] i_green,
    input  wire logic [npc_pkg::CHAN_W-1:0] i_blue,
    output npc_pkg::t_sts                  o_sts,
    npc_out_if.source                      o_res
);
    import npc_pkg::*;

    logic [COLOR_W-1:0]  r_mem [PALETTE_DEPTH];

    logic [CHAN_W-1:0]   r_pix_r, r_pix_g, r_pix_b;

    logic                r_s1_valid;
    logic                r_s1_first;
    logic [AW-1:0]       r_s1_idx;
    logic [COLOR_W-1:0]  r_s1_data;

    logic                r_s2_valid;
    logic                r_s2_first;
    logic [AW-1:0]       r_s2_idx;
    logic [COLOR_W-1:0]  r_s2_color;
    logic [SQ_W-1:0]     r_s2_sq_r, r_s2_sq_g, r_s2_sq_b;

    logic [DIST_W-1:0]   r_best_dist;
    logic [AW-1:0]       r_best_idx;
    logic [COLOR_W-1:0]  r_best_color;

    logic                r_out_valid;
    logic [IDX_W-1:0]    r_out_idx;
    logic [COLOR_W-1:0]  r_out_color;
    logic [DIST_W-1:0]   r_out_dist;

    logic [AW+IDX_W-1:0] w_wr_wide;
    logic [AW+IDX_W-1:0] w_best_wide;
    logic                w_wr_ok;
    logic [CHAN_W-1:0]   w_d_r, w_d_g, w_d_b;
    logic [DIST_W-1:0]   w_dist;

    // The write index is six bits wide; the memory may be deeper or shallower.
    assign w_wr_wide   = {{AW{1'b0}}, i_entry_index};
    assign w_wr_ok     = 32'(i_entry_index) < PALETTE_DEPTH;
    assign w_best_wide = {{IDX_W{1'b0}}, r_best_idx};

    always_ff @(posedge i_clk) begin
        if (i_cmd.pal_wr && w_wr_ok) begin
            r_mem[w_wr_wide[AW-1:0]] <= {i_red, i_green, i_blue};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_s1_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pixel) begin
            r_pix_r <= i_red;
            r_pix_g <= i_green;
            r_pix_b <= i_blue;
        end
    end

    // Absolute channel differences of the entry just read.
    always_comb begin
        w_d_r = (r_pix_r >= r_s1_data[23:16]) ? r_pix_r - r_s1_data[23:16]
                                              : r_s1_data[23:16] - r_pix_r;
        w_d_g = (r_pix_g >= r_s1_data[15:8]) ? r_pix_g - r_s1_data[15:8]
                                             : r_s1_data[15:8] - r_pix_g;
        w_d_b = (r_pix_b >= r_s1_data[7:0]) ? r_pix_b - r_s1_data[7:0]
                                            : r_s1_data[7:0] - r_pix_b;
    end

    assign w_dist = DIST_W'(r_s2_sq_r) + DIST_W'(r_s2_sq_g) + DIST_W'(r_s2_sq_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_cmd.rd_en;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_first <= i_cmd.rd_first;
        r_s1_idx   <= i_rd_addr;
        r_s2_first <= r_s1_first;
        r_s2_idx   <= r_s1_idx;
        r_s2_color <= r_s1_data;
        r_s2_sq_r  <= SQ_W'(w_d_r) * SQ_W'(w_d_r);
        r_s2_sq_g  <= SQ_W'(w_d_g) * SQ_W'(w_d_g);
        r_s2_sq_b  <= SQ_W'(w_d_b) * SQ_W'(w_d_b);
    end

    // Running minimum; strict less-than keeps the lowest index on a tie.
    always_ff @(posedge i_clk) begin
        if (r_s2_valid && (r_s2_first || w_dist < r_best_dist)) begin
            r_best_dist  <= w_dist;
            r_best_idx   <= r_s2_idx;
            r_best_color <= r_s2_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_idx   <= w_best_wide[IDX_W-1:0];
            r_out_color <= r_best_color;
            r_out_dist  <= r_best_dist;
        end
    end

    assign o_sts.pipe_busy = r_s1_valid || r_s2_valid;
    assign o_sts.out_free  = !r_out_valid || o_res.ready;

    assign o_res.valid         = r_out_valid;
    assign o_res.best_index    = r_out_idx;
    assign o_res.red_out       = r_out_color[23:16];
    assign o_res.green_out     = r_out_color[15:8];
    assign o_res.blue_out      = r_out_color[7:0];
    assign o_res.best_distance = r_out_dist;

    a_min_never_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !r_s2_first) |=> r_best_dist <= $past(r_best_dist))
        else $error("running minimum distance increased during a scan");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || o_res.ready))
        else $error("result register loaded while holding an untaken word");

    a_first_leads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_first) |-> !r_s2_valid)
        else $error("new scan entered the pipeline behind an unfinished one");

endmodule

`default_nettype wire

[sv/nearest_palette_color.sv]
// ----------------------------------------------------------------------------
// nearest_palette_color
// Palette quantizer: finds the palette entry nearest to an RGB pixel.
// ----------------------------------------------------------------------------
// Usage:
// The input channel i_pix carries one word per handshake. A word with func
// zero stores its color at entry_index of the palette and gives no result;
// indexes at or beyond the palette depth are dropped. A word with func one
// is a pixel: entries 0 to color_count-1 are scanned for the smallest sum of
// squared channel differences, lowest index winning on a tie, and one result
// word with index, color and distance leaves on o_res.
// color_count is written through i_cfg_we/i_cfg_wdata while the block is
// idle; zero acts as one and values past the depth saturate at the depth.
// A palette write is taken in the idle state. A pixel runs from its
// accepted word to the next accepted word as follows, N being the effective
// count: the scan reads the N entries, one per cycle, from the palette memory
// into one shared distance-and-compare unit, the drain state waits until the
// read and distance pipeline is empty, the done state hands the result over
// once the result register is free, and the idle state takes the next word.
// The result register lets a new word in while an old result waits; if the
// receiver still stalls when the next result is ready, the controller holds
// it. Reset empties the pipeline, drops any result and sets color_count to
// one; palette contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_palette_color #(
    parameter int PALETTE_DEPTH = npc_pkg::DEF_PALETTE_DEPTH
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [npc_pkg::CNT_W-1:0]  i_cfg_wdata,
    npc_in_if.sink                          i_pix,
    npc_out_if.source                       o_res
);
    import npc_pkg::*;

    localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

    t_cmd           w_cmd;
    t_sts           w_sts;
    logic [AW-1:0]  w_rd_addr;
    logic           w_ready;

    assign i_pix.ready = w_ready;

    // The controller walks the scan; the datapath holds the palette, the
    // distance pipeline and the result register.
    npc_ctrl #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_pix.valid),
        .i_func      (i_pix.func),
        .o_ready     (w_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_rd_addr   (w_rd_addr)
    );

    npc_datapath #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_rd_addr     (w_rd_addr),
        .i_entry_index (i_pix.entry_index),
        .i_red         (i_pix.red_in),
        .i_green       (i_pix.green_in),
        .i_blue        (i_pix.blue_in),
        .o_sts         (w_sts),
        .o_res         (o_res)
    );

endmodule

`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the nearest_palette_color quantizer.
// Palette writes and pixels go in over the input channel in random bursts.
// A predictor in the bench keeps its own copy of the palette and of
// color_count, and it works out the nearest entry for every accepted pixel.
// Each result word is checked field by field against the oldest prediction.
// A short directed part covers the extreme colors, the largest distance,
// exact hits, ties and both out-of-range counts. Random phases with many
// search lengths follow. One phase holds the result side off for a long
// stretch so that the block has to stall its input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import npc_pkg::*;

    localparam int DEPTH         = DEF_PALETTE_DEPTH;
    // Longest pixel at full depth plus some margin. This is the
    // wait after the last result before color_count may be rewritten.
    localparam int SETTLE_CYCLES = DEPTH + 16;
    // Length of the long receiver hold-off in the pressure phase.
    localparam int HOLD_CYCLES   = 600;

    // One input word, laid out in the same order as the channel fields.
    typedef struct packed {
        logic              func;
        logic [IDX_W-1:0]  index;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pix_word_t;

    // One result word: chosen entry, its color and its squared distance.
    typedef struct packed {
        logic [IDX_W-1:0]  index;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [DIST_W-1:0] sq_dist;
    } match_t;

    localparam int WORD_W = $bits(pix_word_t);

    // Ready patterns of the result receiver.
    typedef enum logic [1:0] {
        RX_FREE,    // always ready
        RX_COIN,    // ready on a coin toss
        RX_EVERY3,  // ready one cycle out of three
        RX_SPARSE   // mostly stalled
    } rx_mode_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CNT_W-1:0]     i_cfg_wdata;

    npc_in_if  pix_if ();
    npc_out_if res_if ();

    nearest_palette_color dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pix       (pix_if),
        .o_res       (res_if)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state: the palette and the count as the block should hold them.
    logic [COLOR_W-1:0] pal_mem [DEPTH];
    logic [CNT_W-1:0]   color_cnt;

    // The stimulus generator runs ahead of the block, so it keeps its own copy
    // of the palette to aim pixels at entries and to build duplicate colors.
    logic [COLOR_W-1:0] gen_pal [DEPTH];

    pix_word_t word_q [$];    // words waiting to be sent
    match_t    match_q [$];   // predicted results not yet seen

    int       err_cnt    = 0;
    logic     in_fire    = 1'b0;
    int       gap_left   = 0;
    int       burst_left = 1;
    rx_mode_t rx_mode    = RX_FREE;
    int       rx_left    = 0;
    int       rx_tick    = 0;
    logic     hold_res   = 1'b0;
    logic     squeeze_req = 1'b0;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // A count of zero searches entry 0 only; counts past the depth saturate.
    function automatic int eff_count(input logic [CNT_W-1:0] c);
        if (c == '0)
            return 1;
        if (int'(c) > DEPTH)
            return DEPTH;
        return int'(c);
    endfunction

    function automatic int sq_diff(input int a, input int b);
        return (a - b) * (a - b);
    endfunction

    // Scans the palette the way the block does: strict less-than keeps the
    // lowest index when two entries are equally near.
    function automatic match_t nearest_entry(input pix_word_t w);
        match_t             m;
        logic [COLOR_W-1:0] e;
        int                 n;
        int                 d;
        int                 best_d;
        int                 best_k;
        n      = eff_count(color_cnt);
        best_d = 0;
        best_k = 0;
        for (int k = 0; k < n; k++) begin
            e = pal_mem[k];
            d = sq_diff(w.red,   e[2*CHAN_W +: CHAN_W])
              + sq_diff(w.green, e[CHAN_W +: CHAN_W])
              + sq_diff(w.blue,  e[0 +: CHAN_W]);
            if (k == 0 || d < best_d) begin
                best_d = d;
                best_k = k;
            end
        end
        e         = pal_mem[best_k];
        m.index   = IDX_W'(best_k);
        m.red     = e[2*CHAN_W +: CHAN_W];
        m.green   = e[CHAN_W +: CHAN_W];
        m.blue    = e[0 +: CHAN_W];
        m.sq_dist = DIST_W'(best_d);
        return m;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns  %s: got %0d, expected %0d", $realtime, what, got, want);
        err_cnt++;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Channel values lean toward the two extremes now and then.
    function automatic logic [CHAN_W-1:0] rand_chan();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return CHAN_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Moves a channel by a few steps, clamped to its range.
    function automatic logic [CHAN_W-1:0] nudge(input logic [CHAN_W-1:0] c);
        int v;
        v = int'(c) + int'($urandom_range(0, 16)) - 8;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return CHAN_W'(v);
    endfunction

    task automatic push_write(input int idx, input logic [COLOR_W-1:0] color);
        word_q.push_back({FUNC_WRITE, IDX_W'(idx), color});
        gen_pal[idx] = color;
    endtask

    task automatic push_pixel(input logic [COLOR_W-1:0] color);
        word_q.push_back({FUNC_PIXEL, IDX_W'($urandom_range(0, DEPTH - 1)), color});
    endtask

    // One random word. Writes hit any slot, sometimes copying another entry
    // so that ties show up. Pixels are exact hits, near misses of a searched
    // entry, or anything at all.
    task automatic push_random(input int pct_write);
        logic [COLOR_W-1:0] e;
        int                 k;
        if (int'($urandom_range(0, 99)) < pct_write) begin
            if ($urandom_range(0, 4) == 0)
                e = gen_pal[$urandom_range(0, DEPTH - 1)];
            else
                e = {rand_chan(), rand_chan(), rand_chan()};
            push_write($urandom_range(0, DEPTH - 1), e);
        end else begin
            k = $urandom_range(0, eff_count(color_cnt) - 1);
            e = gen_pal[k];
            case ($urandom_range(0, 9))
                0, 1:       push_pixel(e);
                2, 3, 4, 5: push_pixel({nudge(e[2*CHAN_W +: CHAN_W]),
                                        nudge(e[CHAN_W +: CHAN_W]),
                                        nudge(e[0 +: CHAN_W])});
                default:    push_pixel({rand_chan(), rand_chan(), rand_chan()});
            endcase
        end
    endtask

    // The sender pauses here until every word went in and every result came.
    task automatic wait_drained();
        while (word_q.size() != 0 || pix_if.valid || match_q.size() != 0)
            @(posedge i_clk);
    endtask

    // color_count is only written once the block is idle. A palette write
    // leaves no result to wait for, so a fixed settle time comes first.
    task automatic set_color_count(input int value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= CNT_W'(value);
        color_cnt    = CNT_W'(value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_phase(input int count, input int n_words, input int pct_write);
        set_color_count(count);
        repeat (n_words) push_random(pct_write);
    endtask

    // ------------------------------------------------------------------------
    // Driver: offers queued words in bursts. A word stays on the channel until
    // it is taken; between words the payload carries junk with valid low.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        pix_word_t w;
        logic      offer;
        if (i_rst_n && (!pix_if.valid || in_fire)) begin
            offer = 1'b0;
            w     = WORD_W'($urandom);
            if (gap_left > 0) begin
                gap_left--;
            end else if (word_q.size() > 0) begin
                w     = word_q.pop_front();
                offer = 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    // A quarter of the bursts run straight into the next one.
                    burst_left = $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                end
            end
            pix_if.valid       <= offer;
            pix_if.func        <= w.func;
            pix_if.entry_index <= w.index;
            pix_if.red_in      <= w.red;
            pix_if.green_in    <= w.green;
            pix_if.blue_in     <= w.blue;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: the ready pattern is redrawn after each random stretch, and the
    // pressure hold-off overrides it.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        logic rdy;
        if (rx_left > 0) begin
            rx_left--;
        end else begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 300);
        end
        case (rx_mode)
            RX_FREE:   rdy = 1'b1;
            RX_COIN:   rdy = 1'($urandom_range(0, 1));
            RX_EVERY3: begin
                rx_tick++;
                rdy = (rx_tick % 3 == 0);
            end
            default:   rdy = ($urandom_range(0, 4) == 0);
        endcase
        res_if.ready <= rdy && !hold_res;
    end

    // ------------------------------------------------------------------------
    // Scoreboard: predicts on every accepted pixel and checks every accepted
    // result. Both happen in one process so the queue order is fixed.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        pix_word_t w;
        match_t    got;
        match_t    want;
        w = {pix_if.func, pix_if.entry_index, pix_if.red_in, pix_if.green_in,
             pix_if.blue_in};
        in_fire <= i_rst_n && pix_if.valid && pix_if.ready;
        if (i_rst_n && pix_if.valid && pix_if.ready) begin
            if (w.func == FUNC_WRITE)
                pal_mem[w.index] = {w.red, w.green, w.blue};
            else
                match_q.push_back(nearest_entry(w));
        end
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = {res_if.best_index, res_if.red_out, res_if.green_out,
                   res_if.blue_out, res_if.best_distance};
            if (match_q.size() == 0) begin
                report_mismatch("result with no pixel pending, best_index", got.index, -1);
            end else begin
                want = match_q.pop_front();
                if (got.index !== want.index)
                    report_mismatch("best_index", got.index, want.index);
                if (got.red !== want.red)
                    report_mismatch("red_out", got.red, want.red);
                if (got.green !== want.green)
                    report_mismatch("green_out", got.green, want.green);
                if (got.blue !== want.blue)
                    report_mismatch("blue_out", got.blue, want.blue);
                if (got.sq_dist !== want.sq_dist)
                    report_mismatch("best_distance", got.sq_dist, want.sq_dist);
            end
        end
    end

    // Long receiver hold-off. It starts shortly after the pressure phase has
    // queued its words, so the result register and the pipeline fill up and
    // the block has to drop its input ready while the driver keeps offering.
    initial begin
        while (!squeeze_req) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        hold_res = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_res = 1'b0;
    end

    // Generous upper bound on the whole run.
    initial begin
        #5_000_000;
        $display("nearest_palette_color: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_wdata        = '0;
        pix_if.valid       = 1'b0;
        pix_if.func        = FUNC_WRITE;
        pix_if.entry_index = '0;
        pix_if.red_in      = '0;
        pix_if.green_in    = '0;
        pix_if.blue_in     = '0;
        res_if.ready       = 1'b0;
        color_cnt          = CNT_W'(1);
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset count of one: black entry 0 against white gives the largest
        // possible distance, and black against black gives zero.
        push_write(0, 24'h000000);
        push_pixel(24'hFFFFFF);
        push_pixel(24'h000000);

        // A count of zero must still search entry 0.
        set_color_count(0);
        push_pixel(24'h0A141E);
        push_write(1, 24'hFFFFFF);
        push_write(2, 24'hFF0080);
        push_write(3, 24'hFF0080);
        push_write(4, 24'h020000);
        push_write(DEPTH - 1, 24'h7F80FF);

        // Five entries: exact hit on white, a duplicated color where the
        // lower slot must win, an equal distance to black and to entry 4,
        // and two colors in between.
        set_color_count(5);
        push_pixel(24'hFFFFFF);
        push_pixel(24'hFF0080);
        push_pixel(24'h010000);
        push_pixel(24'h7F7F7F);
        push_pixel(24'h80FF00);

        // Load the whole palette before anything searches further up.
        for (int k = 0; k < DEPTH; k++)
            push_write(k, {rand_chan(), rand_chan(), rand_chan()});

        // The largest register value saturates at the palette depth.
        random_phase(127, 8, 0);

        random_phase(DEPTH, 80, 30);
        random_phase(1, 80, 30);
        random_phase(2, 80, 30);
        random_phase(DEPTH + 1, 70, 30);

        // Pressure: a short search so the words pile up quickly behind the
        // held result side.
        set_color_count(3);
        repeat (90) push_random(20);
        squeeze_req = 1'b1;

        random_phase(0, 80, 30);
        random_phase(33, 80, 30);
        random_phase(16, 80, 40);
        random_phase(DEPTH - 1, 70, 30);
        random_phase($urandom_range(1, 127), 80, 30);
        random_phase(7, 80, 20);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_cnt == 0)
            $display("nearest_palette_color: match");
        else
            $display("nearest_palette_color: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
